/* rtl/core/pdt_pkg.sv */
// Shared constants for the pixel desaturate and tint blend block.
// No dependencies; imported by every module of the block.
package pdt_pkg;

    localparam int CHAN_W = 8;
    localparam int PIX_W  = 3 * CHAN_W;

    // Channel full-scale value
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Luma weights for the grey level, sum to 256
    localparam logic [7:0] WEIGHT_RED   = 8'd79;
    localparam logic [7:0] WEIGHT_GREEN = 8'd156;
    localparam logic [7:0] WEIGHT_BLUE  = 8'd21;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_INTENSITY = 2'd1;

endpackage

/* rtl/core/pdt_tint_lane.sv */
// One color channel of the background tint blend, two register stages.
// Depends on pdt_pkg for channel widths and constants.
module pdt_tint_lane
    import pdt_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [CHAN_W-1:0] chan,
    input  logic [CHAN_W-1:0] bg,
    input  logic [CHAN_W-1:0] hue,
    output logic [CHAN_W-1:0] result
);

    logic [2*CHAN_W-1:0] prod_keep_reg;
    logic [2*CHAN_W-1:0] prod_keep_next;
    logic [2*CHAN_W-1:0] prod_bg_reg;
    logic [2*CHAN_W-1:0] prod_bg_next;
    logic [CHAN_W-1:0]   result_reg;
    logic [CHAN_W-1:0]   result_next;
    logic [2*CHAN_W:0]   blend_sum;

    // Weight the source by 255-hue and the background by hue.
    // With hue zero the rounded sum reduces to the source channel itself.
    always_comb
    begin
        prod_keep_next = {{CHAN_W{1'b0}}, CHAN_MAX - hue} * {{CHAN_W{1'b0}}, chan};
        prod_bg_next   = {{CHAN_W{1'b0}}, hue} * {{CHAN_W{1'b0}}, bg};
    end

    // Add with rounding bias and drop the fraction
    always_comb
    begin
        blend_sum   = {1'b0, prod_keep_reg} + {1'b0, prod_bg_reg}
                    + {{(CHAN_W+1){1'b0}}, CHAN_MAX};
        result_next = blend_sum[2*CHAN_W-1:CHAN_W];
    end

    // Advance both stages together with the pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_keep_reg <= prod_keep_next;
            prod_bg_reg   <= prod_bg_next;
            result_reg    <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* rtl/core/pixel_desaturate_and_tint_blend.sv */
// Top level of the pixel desaturate and tint blend pipeline.
// Depends on pdt_pkg and pdt_tint_lane.
//
// Usage:
//   s_axis carries one source and one background RGB pixel per word;
//   m_axis returns one adjusted RGB pixel per accepted word, in order.
//   cfg_wr_en / cfg_index / cfg_data write saturation (index 0) and
//   hue_intensity (index 1); other indexes are ignored. Write only while
//   the pipeline is empty.
//   Five register stages: grey sum, grey scale, grey mix, tint products and
//   tint sum. The edge that accepts a word loads stage 1; the word then moves
//   through stages 2 to 5 and is valid on m_axis once stage 5 holds it. The
//   pipeline takes one word per cycle while m_axis is not stalled.
//   Reset clears all stage valid bits and sets saturation to 255 and
//   hue_intensity to 0, so pixels pass through unchanged.
//   When m_axis_tready is low with a valid output, every stage holds and
//   s_axis_tready drops; no word is lost or repeated. Bubbles already in
//   the pipeline are held in place too, not squeezed out.
module pixel_desaturate_and_tint_blend
    import pdt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // src_red, src_green, src_blue, bg_red, bg_green, bg_blue (lowest first)
    input  logic [2*PIX_W-1:0]   s_axis_tdata,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_red, out_green, out_blue (lowest first)
    output logic [PIX_W-1:0]     m_axis_tdata,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHAN_W-1:0]    cfg_data
);

    localparam int NUM_STAGES = 5;
    localparam int SUM_W      = 2 * CHAN_W;
    localparam int GREY_W     = SUM_W + 1;
    localparam int MIX_W      = SUM_W + 2;

    logic [CHAN_W-1:0]     saturation_reg;
    logic [CHAN_W-1:0]     hue_intensity_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic                  advance;

    // Stage 1: weighted sum and channel products
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  prod1_reg [3];
    logic [SUM_W-1:0]  prod1_next [3];
    logic [CHAN_W-1:0] bg1_reg [3];

    // Stage 2: grey term
    logic [GREY_W-1:0]   grey_reg;
    logic [GREY_W-1:0]   grey_next;
    logic [2*SUM_W-1:0]  grey_prod;
    logic [SUM_W-1:0]    prod2_reg [3];
    logic [CHAN_W-1:0]   bg2_reg [3];

    // Stage 3: mixed channel
    logic [CHAN_W-1:0] mix_reg [3];
    logic [CHAN_W-1:0] mix_next [3];
    logic [MIX_W-1:0]  mix_sum [3];
    logic [CHAN_W-1:0] bg3_reg [3];

    logic [CHAN_W-1:0] src_chan [3];
    logic [CHAN_W-1:0] bg_chan [3];
    logic [CHAN_W-1:0] tint_out [3];

    // Unpack the input word
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            src_chan[i] = s_axis_tdata[i*CHAN_W +: CHAN_W];
            bg_chan[i]  = s_axis_tdata[(i+3)*CHAN_W +: CHAN_W];
        end
    end

    // Hold the pipeline only when the output word is stalled
    assign advance       = !valid_reg[NUM_STAGES-1] || m_axis_tready;
    assign s_axis_tready = advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saturation_reg    <= CHAN_MAX;
            hue_intensity_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SATURATION:    saturation_reg    <= cfg_data;
                REG_HUE_INTENSITY: hue_intensity_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Shift valid bits along with the data
    assign valid_next = {valid_reg[NUM_STAGES-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= valid_next;
    end

    // Stage 1: luma sum and c*saturation; constant weights
    always_comb
    begin
        sum_next = {{CHAN_W{1'b0}}, src_chan[0]} * {{CHAN_W{1'b0}}, WEIGHT_RED}
                 + {{CHAN_W{1'b0}}, src_chan[1]} * {{CHAN_W{1'b0}}, WEIGHT_GREEN}
                 + {{CHAN_W{1'b0}}, src_chan[2]} * {{CHAN_W{1'b0}}, WEIGHT_BLUE};
        for (int i = 0; i < 3; i++)
            prod1_next[i] = {{CHAN_W{1'b0}}, src_chan[i]}
                          * {{CHAN_W{1'b0}}, saturation_reg};
    end

    // Stage 2: grey = floor(sum*(255-sat)/256) + 255; with full saturation
    // the mix below returns the source channel unchanged
    always_comb
    begin
        grey_prod = {{SUM_W{1'b0}}, sum_reg}
                  * {{(2*SUM_W-CHAN_W){1'b0}}, CHAN_MAX - saturation_reg};
        grey_next = {1'b0, grey_prod[SUM_W+CHAN_W-1:CHAN_W]}
                  + {{(GREY_W-CHAN_W){1'b0}}, CHAN_MAX};
    end

    // Stage 3: (c*sat + grey) >> 8, keep low byte
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mix_sum[i]  = {2'b00, prod2_reg[i]} + {1'b0, grey_reg};
            mix_next[i] = mix_sum[i][SUM_W-1:CHAN_W];
        end
    end

    // Payload registers of stages 1 to 3
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg  <= sum_next;
            grey_reg <= grey_next;
            for (int i = 0; i < 3; i++)
            begin
                prod1_reg[i] <= prod1_next[i];
                bg1_reg[i]   <= bg_chan[i];
                prod2_reg[i] <= prod1_reg[i];
                bg2_reg[i]   <= bg1_reg[i];
                mix_reg[i]   <= mix_next[i];
                bg3_reg[i]   <= bg2_reg[i];
            end
        end
    end

    // Stages 4 and 5: background tint, one lane per channel
    for (genvar g = 0; g < 3; g++)
    begin : g_tint
        pdt_tint_lane u_lane (
            .clk    (clk),
            .en     (advance),
            .chan   (mix_reg[g]),
            .bg     (bg3_reg[g]),
            .hue    (hue_intensity_reg),
            .result (tint_out[g])
        );
    end

    // Output word
    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {tint_out[2], tint_out[1], tint_out[0]};

endmodule
